// File: design/cmv_pkg.sv
// ----------------------------------------------------------------------------
// cmv_pkg
// Shared constants, types and the arctangent table of the capsule vertex block.
// ----------------------------------------------------------------------------
package cmv_pkg;

  // grid limits
  localparam int MAX_SLICES = 256;
  localparam int MAX_STACKS = 128;

  // field widths
  localparam int IDX_W    = 9;
  localparam int RAD_W    = 16;
  localparam int SLICE_W  = 9;
  localparam int STACK_W  = 8;
  localparam int TEX_W    = 17;
  localparam int POS_W    = 18;
  localparam int NORM_W   = 16;
  localparam int ADDR_W   = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 136;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_CAP_RADIUS  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_BODY_HEIGHT = 2'd1;
  localparam logic [ADDR_W-1:0] REG_SLICE_COUNT = 2'd2;
  localparam logic [ADDR_W-1:0] REG_STACKS      = 2'd3;

  // long divider: integer bits then fraction bits, one bit a stage
  localparam int DIV_INT_W  = IDX_W;
  localparam int DIV_FRAC_W = 32;
  localparam int DIV_STAGES = DIV_INT_W + DIV_FRAC_W;
  localparam int QUO_W      = DIV_STAGES;
  localparam int REM_W      = 9;

  // lanes: row and column
  localparam int LANES    = 2;
  localparam int LANE_ROW = 0;
  localparam int LANE_COL = 1;

  // cordic
  localparam int ANG_W          = 32;
  localparam int CW             = 34;
  localparam int CORDIC_STEPS   = 24;
  localparam int CORDIC_STAGES  = CORDIC_STEPS + 2;
  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

  // side information through the divider
  typedef struct packed {
    logic oor;
    logic lower;
  } dtag_t;

  // side information through the cordic
  typedef struct packed {
    logic             oor;
    logic             lower;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } tag_t;

  // arctangent of 2^-i as a fraction of a turn, 2^32 = full turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:    a = 30'd536870912;
      5'd1:    a = 30'd316933406;
      5'd2:    a = 30'd167458907;
      5'd3:    a = 30'd85004756;
      5'd4:    a = 30'd42667331;
      5'd5:    a = 30'd21354465;
      5'd6:    a = 30'd10679838;
      5'd7:    a = 30'd5340245;
      5'd8:    a = 30'd2670163;
      5'd9:    a = 30'd1335087;
      5'd10:   a = 30'd667544;
      5'd11:   a = 30'd333772;
      5'd12:   a = 30'd166886;
      5'd13:   a = 30'd83443;
      5'd14:   a = 30'd41722;
      5'd15:   a = 30'd20861;
      5'd16:   a = 30'd10430;
      5'd17:   a = 30'd5215;
      5'd18:   a = 30'd2608;
      5'd19:   a = 30'd1304;
      5'd20:   a = 30'd652;
      5'd21:   a = 30'd326;
      5'd22:   a = 30'd163;
      5'd23:   a = 30'd81;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// File: design/cmv_div.sv
// ----------------------------------------------------------------------------
// cmv_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cmv_div (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         vld_i,
  input  cmv_pkg::dtag_t                               tag_i,
  input  logic [cmv_pkg::LANES-1:0][cmv_pkg::IDX_W-1:0] num_i,
  input  logic [cmv_pkg::LANES-1:0][cmv_pkg::REM_W-1:0] den_i,
  output logic                                         vld_o,
  output cmv_pkg::dtag_t                               tag_o,
  output logic [cmv_pkg::LANES-1:0][cmv_pkg::QUO_W-1:0] quo_o,
  output logic [cmv_pkg::LANES-1:0][cmv_pkg::REM_W-1:0] rem_o,
  output logic [cmv_pkg::LANES-1:0]                    rnd16_o,
  output logic [cmv_pkg::LANES-1:0]                    rnd31_o
);
  import cmv_pkg::*;

  logic                            vld_q [DIV_STAGES];
  dtag_t                           tag_q [DIV_STAGES];
  logic [LANES-1:0][IDX_W-1:0]     num_q [DIV_STAGES];
  logic [LANES-1:0][REM_W-1:0]     rem_q [DIV_STAGES];
  logic [LANES-1:0][QUO_W-1:0]     quo_q [DIV_STAGES];
  logic [LANES-1:0]                r16_q [DIV_STAGES];
  logic [LANES-1:0]                r31_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                        vld_in;
    dtag_t                       tag_in;
    logic [LANES-1:0][IDX_W-1:0] num_in;
    logic [LANES-1:0][REM_W-1:0] rem_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in;
    logic [LANES-1:0]            r16_in;
    logic [LANES-1:0]            r31_in;
    logic [LANES-1:0]            bit_w;
    logic [LANES-1:0][REM_W-1:0] rem_d;
    logic [LANES-1:0][QUO_W-1:0] quo_d;
    logic [LANES-1:0]            r16_d;
    logic [LANES-1:0]            r31_d;

    // stage inputs
    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign tag_in = tag_i;
      assign num_in = num_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign r16_in = '0;
      assign r31_in = '0;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign tag_in = tag_q[s-1];
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign r16_in = r16_q[s-1];
      assign r31_in = r31_q[s-1];
    end

    // numerator bit brought down, zeros once into the fraction
    for (genvar l = 0; l < LANES; l++) begin : g_bit
      if (s < DIV_INT_W) begin : g_int
        assign bit_w[l] = num_in[l][DIV_INT_W-1-s];
      end else begin : g_frac
        assign bit_w[l] = 1'b0;
      end
    end

    // trial subtract
    always_comb begin
      logic [REM_W:0] t;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        t  = {rem_in[l], bit_w[l]};
        ge = (t >= {1'b0, den_i[l]});
        rem_d[l] = ge ? REM_W'(t - {1'b0, den_i[l]}) : t[REM_W-1:0];
        quo_d[l] = {quo_in[l][QUO_W-2:0], ge};
        r16_d[l] = r16_in[l];
        r31_d[l] = r31_in[l];
        if (s == DIV_INT_W + 15) begin
          r16_d[l] = ({rem_d[l], 1'b0} >= {1'b0, den_i[l]});
        end
        if (s == DIV_INT_W + 30) begin
          r31_d[l] = ({rem_d[l], 1'b0} >= {1'b0, den_i[l]});
        end
      end
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    // stage payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s] <= tag_in;
        num_q[s] <= num_in;
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        r16_q[s] <= r16_d;
        r31_q[s] <= r31_d;
      end
    end
  end

  assign vld_o   = vld_q[DIV_STAGES-1];
  assign tag_o   = tag_q[DIV_STAGES-1];
  assign quo_o   = quo_q[DIV_STAGES-1];
  assign rem_o   = rem_q[DIV_STAGES-1];
  assign rnd16_o = r16_q[DIV_STAGES-1];
  assign rnd31_o = r31_q[DIV_STAGES-1];

endmodule

// File: design/cmv_cordic.sv
// ----------------------------------------------------------------------------
// cmv_cordic
// Two-lane pipelined rotation cordic: quadrant fold, 24 micro-rotations, unfold.
// ----------------------------------------------------------------------------
module cmv_cordic (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         vld_i,
  input  cmv_pkg::tag_t                                tag_i,
  input  logic [cmv_pkg::LANES-1:0][cmv_pkg::ANG_W-1:0] ang_i,
  output logic                                         vld_o,
  output cmv_pkg::tag_t                                tag_o,
  output logic [cmv_pkg::LANES-1:0][cmv_pkg::CW-1:0]    cos_o,
  output logic [cmv_pkg::LANES-1:0][cmv_pkg::CW-1:0]    sin_o
);
  import cmv_pkg::*;

  logic                  vld_q  [CORDIC_STAGES];
  tag_t                  tag_q  [CORDIC_STAGES];
  logic signed [CW-1:0]  x_q    [CORDIC_STAGES][LANES];
  logic signed [CW-1:0]  y_q    [CORDIC_STAGES][LANES];
  logic signed [CW-1:0]  z_q    [CORDIC_STAGES][LANES];
  logic                  flip_q [CORDIC_STAGES][LANES];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic vld_in;
    tag_t tag_in;

    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [CW-1:0] x_d;
      logic signed [CW-1:0] y_d;
      logic signed [CW-1:0] z_d;
      logic                 flip_d;

      if (s == 0) begin : g_fold
        // fold angles beyond a quarter turn by a half turn
        always_comb begin
          logic signed [CW-1:0] za;
          za     = $signed({{(CW-ANG_W){ang_i[l][ANG_W-1]}}, ang_i[l]});
          x_d    = CORDIC_GAIN;
          y_d    = '0;
          z_d    = za;
          flip_d = 1'b0;
          if (za > QUARTER_TURN) begin
            z_d    = za - HALF_TURN;
            flip_d = 1'b1;
          end else if (za < -QUARTER_TURN) begin
            z_d    = za + HALF_TURN;
            flip_d = 1'b1;
          end
        end
      end else if (s <= CORDIC_STEPS) begin : g_rot
        // one micro-rotation
        localparam int I = s - 1;
        always_comb begin
          logic signed [CW-1:0] at;
          at     = $signed({{(CW-30){1'b0}}, atan_turn(5'(I))});
          flip_d = flip_q[s-1][l];
          if (z_q[s-1][l] >= 0) begin
            x_d = x_q[s-1][l] - (y_q[s-1][l] >>> I);
            y_d = y_q[s-1][l] + (x_q[s-1][l] >>> I);
            z_d = z_q[s-1][l] - at;
          end else begin
            x_d = x_q[s-1][l] + (y_q[s-1][l] >>> I);
            y_d = y_q[s-1][l] - (x_q[s-1][l] >>> I);
            z_d = z_q[s-1][l] + at;
          end
        end
      end else begin : g_unfold
        // undo the fold by negating both results
        always_comb begin
          flip_d = flip_q[s-1][l];
          z_d    = z_q[s-1][l];
          x_d    = flip_q[s-1][l] ? -x_q[s-1][l] : x_q[s-1][l];
          y_d    = flip_q[s-1][l] ? -y_q[s-1][l] : y_q[s-1][l];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s][l]    <= x_d;
          y_q[s][l]    <= y_d;
          z_q[s][l]    <= z_d;
          flip_q[s][l] <= flip_d;
        end
      end
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s] <= tag_in;
      end
    end
  end

  assign vld_o = vld_q[CORDIC_STAGES-1];
  assign tag_o = tag_q[CORDIC_STAGES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign cos_o[l] = x_q[CORDIC_STAGES-1][l];
    assign sin_o[l] = y_q[CORDIC_STAGES-1][l];
  end

endmodule

// File: design/capsule_mesh_vertex.sv
// ----------------------------------------------------------------------------
// capsule_mesh_vertex
// Grid point of a capsule mesh in, vertex position, normal and texcoords out.
// ----------------------------------------------------------------------------
//  channel    direction  payload
//  s_axis     in         tdata: row_index, column_index
//  m_axis     out        tdata: pos xyz, norm xyz, tex_u, tex_v; tuser: out_of_range
//  cfg        in         register write: index, data
//
//  one request per cycle unless m_axis stalls; a request passes from input
//  to output register through the 41-stage divider, the angle register, the 26-stage
//  cordic and three product and rounding stages
//  a stall on m_axis freezes every stage at once, s_axis_tready follows it
//  reset clears stage valid bits and loads default register values
// ----------------------------------------------------------------------------
module capsule_mesh_vertex (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cmv_pkg::ADDR_W-1:0]    cfg_addr_i,
  input  logic [cmv_pkg::RAD_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // row_index[8:0], column_index[17:9], zero pad
  input  logic [cmv_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
  output logic [cmv_pkg::OUT_W-1:0]     m_axis_tdata,
  // out_of_range
  output logic                          m_axis_tuser
);
  import cmv_pkg::*;

  // rounding helpers
  function automatic logic [POS_W-1:0] pos_round(input logic signed [49:0] v);
    logic signed [49:0] t;
    logic signed [19:0] r;
    t = v + 50'sd536870912;
    r = t[49:30];
    if (r > 20'sd131071) begin
      return 18'h1FFFF;
    end else if (r < -20'sd131072) begin
      return 18'h20000;
    end
    return r[POS_W-1:0];
  endfunction

  function automatic logic [NORM_W-1:0] norm_round(input logic signed [31:0] v);
    logic signed [31:0] t;
    logic signed [16:0] r;
    t = v + 32'sd16384;
    r = t[31:15];
    if (r > 17'sd32767) begin
      return 16'h7FFF;
    end else if (r < -17'sd32768) begin
      return 16'h8000;
    end
    return r[NORM_W-1:0];
  endfunction

  // configuration registers
  logic [RAD_W-1:0]   radius_q;
  logic [RAD_W-1:0]   height_q;
  logic [SLICE_W-1:0] slices_q;
  logic [STACK_W-1:0] stacks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      height_q <= 16'd512;
      slices_q <= 9'd16;
      stacks_q <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_CAP_RADIUS:  radius_q <= cfg_data_i;
        REG_BODY_HEIGHT: height_q <= cfg_data_i;
        REG_SLICE_COUNT: slices_q <= cfg_data_i[SLICE_W-1:0];
        REG_STACKS:      stacks_q <= cfg_data_i[STACK_W-1:0];
        default:         radius_q <= radius_q;
      endcase
    end
  end

  // effective grid size
  logic [SLICE_W-1:0] n_eff;
  logic [STACK_W-1:0] st_eff;
  logic [REM_W-1:0]   den_row;
  logic [REM_W-1:0]   den_col;

  assign n_eff   = (slices_q > SLICE_W'(MAX_SLICES)) ? SLICE_W'(MAX_SLICES) : slices_q;
  assign st_eff  = (stacks_q > STACK_W'(MAX_STACKS)) ? STACK_W'(MAX_STACKS) : stacks_q;
  assign den_row = {st_eff, 1'b0};
  assign den_col = n_eff;

  // global advance: output register empty or being taken
  logic m_vld_q;
  logic en;

  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // entry: range check and hemisphere
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  dtag_t            dtag_in;

  assign row = s_axis_tdata[IDX_W-1:0];
  assign col = s_axis_tdata[2*IDX_W-1:IDX_W];

  always_comb begin
    dtag_in.oor   = (n_eff == '0) || (st_eff == '0) || (row > den_row) || (col > n_eff);
    dtag_in.lower = (row <= {1'b0, st_eff});
  end

  // dividers
  logic                          div_vld;
  dtag_t                         div_tag;
  logic [LANES-1:0][QUO_W-1:0]   div_quo;
  logic [LANES-1:0][REM_W-1:0]   div_rem;
  logic [LANES-1:0]              div_r16;
  logic [LANES-1:0]              div_r31;

  cmv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (s_axis_tvalid),
    .tag_i   (dtag_in),
    .num_i   ({col, row}),
    .den_i   ({den_col, den_row}),
    .vld_o   (div_vld),
    .tag_o   (div_tag),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .rnd16_o (div_r16),
    .rnd31_o (div_r31)
  );

  // angles and texture coordinates
  logic             ang_vld_q;
  tag_t             ang_tag_q;
  logic [ANG_W-1:0] phi_q;
  logic [ANG_W-1:0] theta_q;
  logic             rnd32_col;

  assign rnd32_col = ({div_rem[LANE_COL], 1'b0} >= {1'b0, den_col});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_vld_q <= 1'b0;
    end else if (en) begin
      ang_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_tag_q.oor   <= div_tag.oor;
      ang_tag_q.lower <= div_tag.lower;
      ang_tag_q.tex_u <= div_quo[LANE_COL][32:16] + TEX_W'(div_r16[LANE_COL]);
      ang_tag_q.tex_v <= div_quo[LANE_ROW][32:16] + TEX_W'(div_r16[LANE_ROW]);
      theta_q         <= div_quo[LANE_COL][31:0] + ANG_W'(rnd32_col);
      phi_q           <= div_quo[LANE_ROW][32:1] + ANG_W'(div_r31[LANE_ROW])
                         - 32'h4000_0000;
    end
  end

  // sine and cosine
  logic                     cor_vld;
  tag_t                     cor_tag;
  logic [LANES-1:0][CW-1:0] cor_cos;
  logic [LANES-1:0][CW-1:0] cor_sin;

  cmv_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (ang_vld_q),
    .tag_i  (ang_tag_q),
    .ang_i  ({theta_q, phi_q}),
    .vld_o  (cor_vld),
    .tag_o  (cor_tag),
    .cos_o  (cor_cos),
    .sin_o  (cor_sin)
  );

  // direction products
  logic signed [31:0] cp;
  logic signed [31:0] sp;
  logic signed [31:0] ct;
  logic signed [31:0] stt;
  logic signed [63:0] px_p;
  logic signed [63:0] pz_p;

  assign cp   = $signed(cor_cos[LANE_ROW][31:0]);
  assign sp   = $signed(cor_sin[LANE_ROW][31:0]);
  assign ct   = $signed(cor_cos[LANE_COL][31:0]);
  assign stt  = $signed(cor_sin[LANE_COL][31:0]);
  assign px_p = cp * ct + 64'sd536870912;
  assign pz_p = cp * stt + 64'sd536870912;

  logic               m1_vld_q;
  tag_t               m1_tag_q;
  logic signed [31:0] m1_px_q;
  logic signed [31:0] m1_py_q;
  logic signed [31:0] m1_pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= cor_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_tag_q <= cor_tag;
      m1_px_q  <= px_p[61:30];
      m1_py_q  <= sp;
      m1_pz_q  <= pz_p[61:30];
    end
  end

  // radius scaling and body shift
  logic signed [16:0] rad_s;
  logic signed [49:0] shift;

  assign rad_s = $signed({1'b0, radius_q});
  assign shift = m1_tag_q.lower ? -$signed({5'b0, height_q, 29'b0})
                                :  $signed({5'b0, height_q, 29'b0});

  logic               m2_vld_q;
  tag_t               m2_tag_q;
  logic signed [49:0] m2_x_q;
  logic signed [49:0] m2_y_q;
  logic signed [49:0] m2_z_q;
  logic signed [31:0] m2_nx_q;
  logic signed [31:0] m2_ny_q;
  logic signed [31:0] m2_nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_tag_q <= m1_tag_q;
      m2_x_q   <= 50'(rad_s * m1_px_q);
      m2_y_q   <= 50'(rad_s * m1_py_q) + shift;
      m2_z_q   <= 50'(rad_s * m1_pz_q);
      m2_nx_q  <= m1_px_q;
      m2_ny_q  <= m1_py_q;
      m2_nz_q  <= m1_pz_q;
    end
  end

  // output register: rounding, saturation, out of range clears the fields
  logic [OUT_W-1:0] out_data_d;
  logic [OUT_W-1:0] out_data_q;
  logic             out_user_q;

  always_comb begin
    out_data_d = {m2_tag_q.tex_v, m2_tag_q.tex_u,
                  norm_round(m2_nz_q), norm_round(m2_ny_q), norm_round(m2_nx_q),
                  pos_round(m2_z_q), pos_round(m2_y_q), pos_round(m2_x_q)};
    if (m2_tag_q.oor) begin
      out_data_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_user_q <= m2_tag_q.oor;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out of range result carries data");

  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready not tied to output stall");

  a_tex_u : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[118:102] <= 17'd65536)
    else $error("tex_u above one");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && !m_axis_tready |=> $stable(out_data_q) && m_vld_q)
    else $error("stalled result changed");

endmodule

// File: tb/capsule_mesh_vertex_tb.sv
// ----------------------------------------------------------------------------
// capsule_mesh_vertex_tb
// Streams grid points through the capsule vertex block under several register
// settings and compares every vertex with a bit-exact fixed-point predictor.
// Both stream sides idle at random, and registers change only while idle.
// ----------------------------------------------------------------------------
module capsule_mesh_vertex_tb;
  import cmv_pkg::*;

  // expected vertex
  typedef struct {
    logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
    logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
    logic [TEX_W-1:0]         tex_u, tex_v;
    logic                     oor;
  } vertex_t;

  // vertex predictor and store of pending vertices
  class vertex_board;
    int unsigned radius = 256, height = 512, slices = 16, stacks = 8;
    vertex_t     pending[$];
    int          errors = 0;
    int          checked = 0;
    int          oor_seen = 0;
    longint      atan_tab[CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

    function void set_reg(logic [ADDR_W-1:0] idx, int unsigned val);
      case (idx)
        REG_CAP_RADIUS:  radius = val & 16'hFFFF;
        REG_BODY_HEIGHT: height = val & 16'hFFFF;
        REG_SLICE_COUNT: slices = val & 9'h1FF;
        REG_STACKS:      stacks = val & 8'hFF;
        default: ;
      endcase
    endfunction

    // rotation-mode cordic on a turn fraction, quarter-turn folding
    function void sin_cos(longint ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit     flip;
      z = ang; x = 652032874; y = 0; flip = 0;
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      if (z > 64'sd1073741824) begin
        z -= 64'sd2147483648; flip = 1;
      end else if (z < -64'sd1073741824) begin
        z += 64'sd2147483648; flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint rnd(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // note an accepted request
    function void note(logic [8:0] row, logic [8:0] col);
      vertex_t          v;
      longint unsigned  n, st, phi, theta;
      longint           cp, sp, ct, stt, px, pz, shift;
      n  = slices > MAX_SLICES ? MAX_SLICES : slices;
      st = stacks > MAX_STACKS ? MAX_STACKS : stacks;
      v = '{default: 0};
      if (n == 0 || st == 0 || row > 2 * st || col > n) begin
        v.oor = 1'b1;
      end else begin
        phi   = ((((64'(row) << 30) + st / 2) / st) - 64'd1073741824) & 64'hFFFFFFFF;
        theta = (((64'(col) << 32) + n / 2) / n) & 64'hFFFFFFFF;
        sin_cos(longint'(phi), cp, sp);
        sin_cos(longint'(theta), ct, stt);
        px = rnd(cp * ct, 30);
        pz = rnd(cp * stt, 30);
        shift = longint'(height) <<< 29;
        if (row <= st) shift = -shift;
        v.pos_x  = POS_W'(clip(rnd(longint'(radius) * px, 30), -131072, 131071));
        v.pos_y  = POS_W'(clip(rnd(longint'(radius) * sp + shift, 30), -131072, 131071));
        v.pos_z  = POS_W'(clip(rnd(longint'(radius) * pz, 30), -131072, 131071));
        v.norm_x = NORM_W'(clip(rnd(px, 15), -32768, 32767));
        v.norm_y = NORM_W'(clip(rnd(sp, 15), -32768, 32767));
        v.norm_z = NORM_W'(clip(rnd(pz, 15), -32768, 32767));
        v.tex_u  = TEX_W'(((64'(col) << 16) + n / 2) / n);
        v.tex_v  = TEX_W'(((64'(row) << 16) + st) / (2 * st));
      end
      pending = {pending, v};
    endfunction

    function void field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // check one delivered vertex against the oldest expectation
    function void check(logic [OUT_W-1:0] d, logic oor);
      vertex_t e;
      if (pending.size() == 0) begin
        $error("vertex delivered with none expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.oor) oor_seen++;
      field("pos_x",  e.pos_x,  $signed(d[17:0]));
      field("pos_y",  e.pos_y,  $signed(d[35:18]));
      field("pos_z",  e.pos_z,  $signed(d[53:36]));
      field("norm_x", e.norm_x, $signed(d[69:54]));
      field("norm_y", e.norm_y, $signed(d[85:70]));
      field("norm_z", e.norm_z, $signed(d[101:86]));
      field("tex_u",  e.tex_u,  d[118:102]);
      field("tex_v",  e.tex_v,  d[135:119]);
      field("out_of_range", e.oor, oor);
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic [ADDR_W-1:0]  cfg_addr_i = REG_CAP_RADIUS;
  logic [RAD_W-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tuser;

  vertex_board board = new();
  int          req_taken = 0;
  int          sent = 0;
  bit          stimulus_done = 0;

  capsule_mesh_vertex dut (.*);

  always #2 clk_i = ~clk_i;

  // request and vertex monitors
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      board.note(s_axis_tdata[8:0], s_axis_tdata[17:9]);
      req_taken++;
    end
    if (m_axis_tvalid && m_axis_tready)
      board.check(m_axis_tdata, m_axis_tuser);
  end

  // receiver stall pattern: modes are drawn at random and held for a random span
  initial begin
    int mode, left;
    mode = 0; left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
        2:       m_axis_tready <= ($urandom_range(0, 9) < 2);
        default: m_axis_tready <= ((left % 8) < 5);
      endcase
    end
  end

  task automatic write_reg(logic [ADDR_W-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= RAD_W'(val);
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(int unsigned r, int unsigned h, int unsigned n, int unsigned s);
    write_reg(REG_CAP_RADIUS, r);
    write_reg(REG_BODY_HEIGHT, h);
    write_reg(REG_SLICE_COUNT, n);
    write_reg(REG_STACKS, s);
  endtask

  // wait for every vertex, then let the pipeline settle
  task automatic drain();
    while (board.pending.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // present one request and hold it until taken; called at a falling edge
  task automatic send(logic [8:0] row, logic [8:0] col);
    int seen;
    seen = req_taken;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, col, row};
    do @(negedge clk_i); while (req_taken == seen);
    sent++;
  endtask

  // random grid points in bursts, mostly inside the grid
  task automatic burst_run(int count);
    int unsigned n, st, burst;
    logic [8:0]  row, col;
    n  = board.slices > MAX_SLICES ? MAX_SLICES : board.slices;
    st = board.stacks > MAX_STACKS ? MAX_STACKS : board.stacks;
    @(negedge clk_i);
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && count > 0) begin
        if ($urandom_range(0, 9) < 8 && n != 0 && st != 0) begin
          row = 9'($urandom_range(0, 2 * st));
          col = 9'($urandom_range(0, n));
        end else begin
          row = 9'($urandom_range(0, 511));
          col = 9'($urandom_range(0, 511));
        end
        send(row, col);
        burst--; count--;
      end
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    logic [8:0] dir_rows[9] = '{0, 1, 7, 8, 9, 15, 16, 17, 511};
    logic [8:0] dir_cols[9] = '{0, 4, 8, 12, 16, 17, 255, 256, 511};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: poles, equator both sides, seam, grid edges and beyond
    @(negedge clk_i);
    for (int i = 0; i < 9; i++) send(dir_rows[i], dir_cols[(i * 4) % 9]);
    for (int i = 0; i < 9; i++) send(dir_rows[8 - i], dir_cols[i]);
    send(9'd8, 9'd16);
    send(9'd16, 9'd0);
    s_axis_tvalid <= 1'b0;
    burst_run(200);
    drain();

    // extremes: largest sizes and radius, smallest sizes and zero radius
    configure(65535, 65535, 256, 128);
    burst_run(250);
    drain();
    configure(0, 0, 1, 1);
    burst_run(150);
    drain();
    // counts above the limits saturate
    configure(1, 65535, 511, 255);
    burst_run(250);
    drain();
    // zero slice count, then zero stack count
    configure(12345, 300, 0, 5);
    burst_run(60);
    drain();
    configure(700, 100, 7, 0);
    burst_run(60);
    drain();
    configure(65535, 0, 3, 2);
    burst_run(150);
    drain();
    for (int k = 0; k < 3; k++) begin
      configure($urandom_range(1, 65535), $urandom_range(0, 65535),
                $urandom_range(1, 256), $urandom_range(1, 128));
      burst_run(200);
      drain();
    end

    $display("covered %0d grid points over 10 register settings, %0d vertices checked",
             sent, board.checked);
    $display("%0d of them out of grid, including zero counts and saturated counts",
             board.oor_seen);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d vertices outstanding", board.pending.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: capsule_mesh_vertex.f
design/cmv_pkg.sv
design/cmv_div.sv
design/cmv_cordic.sv
design/capsule_mesh_vertex.sv
tb/capsule_mesh_vertex_tb.sv
